/* rtl/core/swks_pkg.sv */
`default_nettype none

package swks_pkg;

  // default sizes
  localparam int DEF_MAX_WINDOW = 64;
  localparam int DEF_VALUE_BITS = 30;
  localparam int DEF_SUM_BITS   = DEF_VALUE_BITS + $clog2(DEF_MAX_WINDOW);
  localparam int DEF_COST_BITS  = DEF_SUM_BITS + 1;

  // configuration register fields
  localparam int TAKE_BITS     = 7;
  localparam int SPAN_BITS     = 6;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 7;

  localparam logic [CFG_IDX_BITS-1:0] REG_TAKE_COUNT  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SPAN = CFG_IDX_BITS'(1);

  localparam logic [TAKE_BITS-1:0] TAKE_COUNT_RST  = TAKE_BITS'(2);
  localparam logic [SPAN_BITS-1:0] WINDOW_SPAN_RST = SPAN_BITS'(63);

  // operation broadcast to every cell of the sorted chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_DROP   = 2'd1,
    OP_INSERT = 2'd2,
    OP_CLEAR  = 2'd3
  } cell_op_t;

  // status a cell shows to the cell above it
  typedef struct packed {
    logic valid;
    logic gt;
  } cell_flag_t;

endpackage

`default_nettype wire

/* rtl/core/swks_if.sv */
`default_nettype none

// sample stream
interface swks_sample_if import swks_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] sample;
  logic                  last_item;

  modport source (output valid, output sample, output last_item, input ready);
  modport sink   (input valid, input sample, input last_item, output ready);
endinterface

// result stream
interface swks_result_if import swks_pkg::*; #(
  parameter int COST_BITS = DEF_COST_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [COST_BITS-1:0] total_cost;
  logic                 found;

  modport source (output valid, output total_cost, output found, input ready);
  modport sink   (input valid, input total_cost, input found, output ready);
endinterface

// register write channel
interface swks_cfg_if import swks_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/swks_ram.sv */
`default_nettype none

module swks_ram import swks_pkg::*; #(
  parameter int WIDTH = DEF_VALUE_BITS,
  parameter int DEPTH = DEF_MAX_WINDOW
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/swks_cell.sv */
`default_nettype none

module swks_cell import swks_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int SUM_BITS   = DEF_SUM_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cell_op_t              op,
  input  wire logic [VALUE_BITS-1:0] key,
  input  wire logic                  sum_en,
  input  wire logic [VALUE_BITS-1:0] lo_value,
  input  wire cell_flag_t            lo_flag,
  input  wire logic [VALUE_BITS-1:0] hi_value,
  input  wire logic                  hi_valid,
  input  wire logic [SUM_BITS-1:0]   sum_in,
  output logic      [VALUE_BITS-1:0] value,
  output cell_flag_t                 flag,
  output logic      [SUM_BITS-1:0]   sum_out
);

  logic                  valid;
  logic                  valid_next;
  logic [VALUE_BITS-1:0] value_next;
  logic                  gt;

  // chain is ascending, so gt rises monotonically along the row
  assign gt         = valid && (value > key);
  assign flag.valid = valid;
  assign flag.gt    = gt;

  // drop pulls the upper neighbour down, insert pushes the lower one up
  always_comb begin
    value_next = value;
    valid_next = valid;
    unique case (op)
      OP_HOLD: begin
      end
      OP_DROP: begin
        if (valid && (value >= key)) begin
          value_next = hi_value;
          valid_next = hi_valid;
        end
      end
      OP_INSERT: begin
        if (lo_flag.gt) begin
          value_next = lo_value;
          valid_next = 1'b1;
        end else if (lo_flag.valid && (gt || !valid)) begin
          value_next = key;
          valid_next = 1'b1;
        end
      end
      OP_CLEAR: begin
        valid_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // running prefix sum, one cell further each cycle
  always_ff @(posedge clk) begin
    sum_out <= sum_in + (sum_en ? SUM_BITS'(value) : '0);
  end

endmodule

`default_nettype wire

/* rtl/core/sliding_window_k_smallest_sum_min.sv */
// channel   | dir | beat contents               | handshake
// ----------+-----+-----------------------------+------------------
// samples   | in  | sample, last_item           | valid / ready
// results   | out | total_cost, found           | valid / ready
// cfg       | in  | index, data                 | valid / ready (ready always high)
//
// An item runs check, a drop and a new check per dropped value, insert, sum if the
// window holds at least take_count values, and finish; a sequence's base item goes
// from idle straight to finish. Sum waits while the prefix sum ripples through the
// whole cell row; a drop costs a registered arrival-ring read plus one cell shift.
// Synchronous rst clears sequence state and cell valid bits and resets registers.
// A waiting result holds in its output register; a new sequence is taken meanwhile
// and only its own last beat waits for that register to empty.
`default_nettype none

module sliding_window_k_smallest_sum_min import swks_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input wire logic      clk,
  input wire logic      rst,
  swks_sample_if.sink   samples,
  swks_result_if.source results,
  swks_cfg_if.sink      cfg
);

  localparam int AW        = $clog2(MAX_WINDOW);
  localparam int FW        = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS  = VALUE_BITS + $clog2(MAX_WINDOW);
  localparam int COST_BITS = SUM_BITS + 1;
  localparam logic [31:0] MAXW32 = 32'(MAX_WINDOW);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_DROP   = 6'b000100,
    ST_INSERT = 6'b001000,
    ST_SUM    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [TAKE_BITS-1:0]  take_count;
  logic [SPAN_BITS-1:0]  window_span;
  logic [VALUE_BITS-1:0] in_value;
  logic                  in_last;
  logic [VALUE_BITS-1:0] base_value;
  logic                  expect_base;
  logic [AW-1:0]         head;
  logic [FW-1:0]         fill;
  logic [SUM_BITS-1:0]   best_sum;
  logic                  best_found;
  logic [FW-1:0]         wait_cnt;
  logic                  out_valid;
  logic [COST_BITS-1:0]  out_cost;
  logic                  out_found;

  logic                  in_fire;
  logic [31:0]           span_plus;
  logic [31:0]           cap;
  logic                  need_drop;
  logic [31:0]           oldest_wide;
  logic [AW-1:0]         oldest;
  logic [AW-1:0]         head_inc;
  logic                  slot_free;
  logic                  finish_out;
  logic                  sum_done;
  logic [VALUE_BITS-1:0] ring_rdata;
  cell_op_t              op;
  logic [VALUE_BITS-1:0] key;
  logic [SUM_BITS-1:0]   psum_last;

  logic [VALUE_BITS-1:0] cell_value [MAX_WINDOW];
  cell_flag_t            cell_flag  [MAX_WINDOW];
  logic [SUM_BITS-1:0]   cell_sum   [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] sum_en;

  // handshakes
  assign samples.ready = (state == ST_IDLE);
  assign in_fire       = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  assign results.valid      = out_valid;
  assign results.total_cost = out_cost;
  assign results.found      = out_found;

  // window capacity, saturating at the cell count
  assign span_plus = 32'(window_span) + 32'd1;
  assign cap       = (span_plus > MAXW32) ? MAXW32 : span_plus;
  assign need_drop = (fill != '0) && (32'(fill) >= cap);

  // ring slot of the oldest value still in the window
  assign oldest_wide = (32'(head) >= 32'(fill)) ? (32'(head) - 32'(fill))
                                                : (32'(head) + MAXW32 - 32'(fill));
  assign oldest      = oldest_wide[AW-1:0];
  assign head_inc    = (head == AW'(MAX_WINDOW - 1)) ? '0 : head + AW'(1);

  assign slot_free  = !out_valid || results.ready;
  assign finish_out = (state == ST_FINISH) && in_last && slot_free;
  assign sum_done   = (wait_cnt == FW'(MAX_WINDOW));

  // arrival order of the window values
  swks_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_INSERT),
    .waddr (head),
    .wdata (in_value),
    .raddr (oldest),
    .rdata (ring_rdata)
  );

  // broadcast to the cell row
  always_comb begin
    op  = OP_HOLD;
    key = in_value;
    if (state == ST_DROP) begin
      op  = OP_DROP;
      key = ring_rdata;
    end else if (state == ST_INSERT) begin
      op = OP_INSERT;
    end else if (finish_out) begin
      op = OP_CLEAR;
    end
  end

  // sorted cell row
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [VALUE_BITS-1:0] lo_value;
    cell_flag_t            lo_flag;
    logic [VALUE_BITS-1:0] hi_value;
    logic                  hi_valid;
    logic [SUM_BITS-1:0]   sum_in;

    assign sum_en[i] = (32'(take_count) > 32'(i));

    if (i == 0) begin : g_lo_end
      assign lo_value = '0;
      assign lo_flag  = '{valid: 1'b1, gt: 1'b0};
      assign sum_in   = '0;
    end else begin : g_lo
      assign lo_value = cell_value[i-1];
      assign lo_flag  = cell_flag[i-1];
      assign sum_in   = cell_sum[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_hi_end
      assign hi_value = '0;
      assign hi_valid = 1'b0;
    end else begin : g_hi
      assign hi_value = cell_value[i+1];
      assign hi_valid = cell_flag[i+1].valid;
    end

    swks_cell #(
      .VALUE_BITS (VALUE_BITS),
      .SUM_BITS   (SUM_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (op),
      .key      (key),
      .sum_en   (sum_en[i]),
      .lo_value (lo_value),
      .lo_flag  (lo_flag),
      .hi_value (hi_value),
      .hi_valid (hi_valid),
      .sum_in   (sum_in),
      .value    (cell_value[i]),
      .flag     (cell_flag[i]),
      .sum_out  (cell_sum[i])
    );
  end

  assign psum_last = cell_sum[MAX_WINDOW-1];

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = expect_base ? ST_FINISH : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = need_drop ? ST_DROP : ST_INSERT;
      end
      ST_DROP: begin
        state_next = ST_CHECK;
      end
      ST_INSERT: begin
        state_next = ((32'(fill) + 32'd1) >= 32'(take_count)) ? ST_SUM : ST_FINISH;
      end
      ST_SUM: begin
        if (sum_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!in_last || slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      take_count  <= TAKE_COUNT_RST;
      window_span <= WINDOW_SPAN_RST;
      expect_base <= 1'b1;
      head        <= '0;
      fill        <= '0;
      best_sum    <= '1;
      best_found  <= 1'b0;
      wait_cnt    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      // register writes
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_TAKE_COUNT:  take_count  <= cfg.data[TAKE_BITS-1:0];
          REG_WINDOW_SPAN: window_span <= cfg.data[SPAN_BITS-1:0];
          default: begin
          end
        endcase
      end

      if (in_fire && expect_base) begin
        expect_base <= 1'b0;
      end

      if (state == ST_DROP) begin
        fill <= fill - FW'(1);
      end

      if (state == ST_INSERT) begin
        fill     <= fill + FW'(1);
        head     <= head_inc;
        wait_cnt <= '0;
      end

      // minimum of the windowed sums
      if (state == ST_SUM) begin
        if (sum_done) begin
          if (psum_last < best_sum) begin
            best_sum <= psum_last;
          end
          best_found <= 1'b1;
        end else begin
          wait_cnt <= wait_cnt + FW'(1);
        end
      end

      // output register and end of sequence
      if (finish_out) begin
        out_valid   <= 1'b1;
        expect_base <= 1'b1;
        head        <= '0;
        fill        <= '0;
        best_sum    <= '1;
        best_found  <= 1'b0;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_value <= samples.sample;
      in_last  <= samples.last_item;
      if (expect_base) begin
        base_value <= samples.sample;
      end
    end
    if (finish_out) begin
      out_cost  <= COST_BITS'(base_value) + (best_found ? COST_BITS'(best_sum) : '0);
      out_found <= best_found;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/swks_checker.sv */
`default_nettype none

module swks_checker import swks_pkg::*; #(
  parameter int COST_BITS = DEF_COST_BITS
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [COST_BITS-1:0] out_cost,
  input wire logic                 out_found
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_cost) && $stable(out_found))
    else $error("result beat changed while stalled");

  // one item at a time: no beat is taken in the cycle after a beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample beat taken back to back");

  // a result only appears after the sequencer has left idle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared straight from idle");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind sliding_window_k_smallest_sum_min swks_checker #(
  .COST_BITS (COST_BITS)
) u_swks_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_cost  (results.total_cost),
  .out_found (results.found)
);

`default_nettype wire

/* sim/sliding_window_k_smallest_sum_min_test.sv */
`timescale 1ns / 100ps

module sliding_window_k_smallest_sum_min_test;
  import swks_pkg::*;

  localparam int VB = DEF_VALUE_BITS;
  localparam int CW = DEF_COST_BITS;
  localparam int SW = DEF_SUM_BITS;
  localparam int MAX_WIN = DEF_MAX_WINDOW;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned SETTLE_CYCLES = 250;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  // register indexes past the end of the list, ignored by the block
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_2 = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_3 = CFG_IDX_BITS'(3);

  typedef struct packed {
    logic [VB-1:0] value;
    logic          last;
  } sample_beat_t;

  typedef struct packed {
    logic [CW-1:0] cost;
    logic          found;
  } cost_result_t;

  logic clk = 1'b0;
  logic rst;

  swks_sample_if #(.VALUE_BITS(VB)) samples ();
  swks_result_if #(.COST_BITS(CW)) results ();
  swks_cfg_if cfg ();

  sliding_window_k_smallest_sum_min i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus and expectations
  sample_beat_t pending_beats[$];
  cost_result_t expected_costs[$];

  // control flags set by the stimulus process
  bit idle_on = 1'b1;
  bit pressure_on = 1'b0;

  // run statistics
  int unsigned error_count = 0;
  int unsigned beats_in = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned sequences = 0;

  // own copy of registers and sequence state
  logic [TAKE_BITS-1:0] take_model = TAKE_COUNT_RST;
  logic [SPAN_BITS-1:0] span_model = WINDOW_SPAN_RST;
  logic [VB-1:0]        base_model = '0;
  bit                   awaiting_base = 1'b1;
  logic [VB-1:0]        arrival_order[MAX_WIN];
  int unsigned          ring_pos = 0;
  logic [VB-1:0]        ranked[MAX_WIN];
  int unsigned          fill_model = 0;
  logic [SW-1:0]        best_model = '1;
  bit                   best_hit = 1'b0;

  // move the window on by one accepted sample, queue the cost on a last beat
  task automatic advance_window(input logic [VB-1:0] v, input logic last);
    int unsigned cap, slot, i, k;
    logic [VB-1:0] oldest;
    logic [SW-1:0] s;
    cost_result_t r;
    if (awaiting_base) begin
      base_model = v;
      awaiting_base = 1'b0;
    end else begin
      cap = int'(span_model) + 1;
      if (cap > MAX_WIN) cap = MAX_WIN;
      // evict oldest values until the new one fits
      while (fill_model > 0 && fill_model >= cap) begin
        slot = (ring_pos + MAX_WIN - fill_model) % MAX_WIN;
        oldest = arrival_order[slot];
        i = 0;
        while (i < fill_model && ranked[i] != oldest) i++;
        if (i >= fill_model) i = fill_model - 1;
        for (; i + 1 < fill_model; i++) ranked[i] = ranked[i + 1];
        fill_model--;
      end
      // sorted insert
      i = fill_model;
      while (i > 0 && ranked[i - 1] > v) begin
        ranked[i] = ranked[i - 1];
        i--;
      end
      ranked[i] = v;
      fill_model++;
      arrival_order[ring_pos] = v;
      ring_pos = (ring_pos + 1) % MAX_WIN;
      // sum of the smallest values, keep the minimum
      if (fill_model >= int'(take_model)) begin
        s = '0;
        for (k = 0; k < int'(take_model) && k < fill_model; k++) s += SW'(ranked[k]);
        if (s < best_model) best_model = s;
        best_hit = 1'b1;
      end
    end
    if (last) begin
      r.found = best_hit;
      r.cost = best_hit ? CW'(base_model) + CW'(best_model) : CW'(base_model);
      expected_costs.push_back(r);
      base_model = '0;
      awaiting_base = 1'b1;
      ring_pos = 0;
      fill_model = 0;
      best_model = '1;
      best_hit = 1'b0;
      sequences++;
    end
  endtask

  // sample driver
  int unsigned gap_left = 0;

  always @(posedge clk) begin : feed
    sample_beat_t b;
    if (rst) begin
      samples.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (samples.valid && samples.ready) begin
        advance_window(samples.sample, samples.last_item);
        beats_in++;
      end
      if (!samples.valid || samples.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          samples.valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          b = pending_beats.pop_front();
          samples.valid <= 1'b1;
          samples.sample <= b.value;
          samples.last_item <= b.last;
          if (idle_on && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 8);
        end else begin
          samples.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  int unsigned stall_left = 0;
  bit pressure_started = 1'b0;

  always @(posedge clk) begin : watch_results
    int unsigned stall_next;
    cost_result_t want;
    if (!rst && results.valid && results.ready) begin
      results_checked++;
      if (expected_costs.size() == 0) begin
        error_count++;
        $display("%0t: result beat with none expected, got cost %0d found %0b",
                 $time, results.total_cost, results.found);
      end else begin
        want = expected_costs.pop_front();
        if (results.total_cost !== want.cost || results.found !== want.found) begin
          error_count++;
          $display("%0t: result mismatch, expected cost %0d found %0b, got cost %0d found %0b",
                   $time, want.cost, want.found, results.total_cost, results.found);
        end
      end
    end
    if (rst) begin
      stall_left <= 0;
      results.ready <= 1'b1;
    end else begin
      stall_next = stall_left;
      if (pressure_on && !pressure_started) begin
        stall_next = LONG_HOLD;
        pressure_started <= 1'b1;
      end else if (stall_next != 0) begin
        stall_next--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_next = $urandom_range(1, 8);
      end
      stall_left <= stall_next;
      results.ready <= (stall_next == 0);
    end
  end

  // watchdog on cycles with no beat on any channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)
        || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [VB-1:0] next_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return VB'($urandom_range(0, 15));
      4: return '1 - VB'($urandom_range(0, 15));
      default: return VB'($urandom);
    endcase
  endfunction

  task automatic push_beat(input logic [VB-1:0] v, input logic last);
    sample_beat_t b;
    b.value = v;
    b.last = last;
    pending_beats.push_back(b);
  endtask

  task automatic queue_sequence(input int unsigned len, input bit close);
    int unsigned k;
    for (k = 0; k < len; k++) push_beat(next_value(), close && (k == len - 1));
  endtask

  // write one register, only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_TAKE_COUNT) take_model = val[TAKE_BITS-1:0];
    else if (idx == REG_WINDOW_SPAN) span_model = val[SPAN_BITS-1:0];
    reg_writes++;
  endtask

  // wait until every queued beat is in and every result is out, then let the block finish
  task automatic settle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || samples.valid || expected_costs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned random_queued, phase, phase_goal, n, len;
    bit close;
    logic [TAKE_BITS-1:0] take;
    logic [SPAN_BITS-1:0] span;
    rst = 1'b1;
    samples.valid = 1'b0;
    samples.sample = '0;
    samples.last_item = 1'b0;
    results.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_TAKE_COUNT;
    cfg.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one-item sequence, then extreme values
    push_beat('1, 1'b1);
    push_beat('0, 1'b0);
    push_beat('1, 1'b0);
    push_beat('1, 1'b0);
    push_beat('0, 1'b0);
    push_beat(VB'(5), 1'b1);
    settle();

    // empty sum counts when nothing is taken
    write_reg(REG_TAKE_COUNT, CFG_DATA_BITS'(0));
    push_beat(VB'(7), 1'b0);
    push_beat(VB'(3), 1'b1);
    settle();

    // take count larger than any window
    write_reg(REG_TAKE_COUNT, CFG_DATA_BITS'(127));
    push_beat(VB'(100), 1'b0);
    push_beat(VB'(1), 1'b0);
    push_beat(VB'(2), 1'b0);
    push_beat(VB'(3), 1'b1);
    settle();

    // span lowered in the middle of a sequence
    write_reg(REG_TAKE_COUNT, CFG_DATA_BITS'(1));
    write_reg(REG_WINDOW_SPAN, CFG_DATA_BITS'(63));
    queue_sequence(11, 1'b0);
    settle();
    write_reg(REG_WINDOW_SPAN, CFG_DATA_BITS'(7'h42));
    push_beat(next_value(), 1'b0);
    push_beat(next_value(), 1'b1);
    settle();

    // writes past the register list change nothing
    write_reg(REG_UNUSED_2, CFG_DATA_BITS'($urandom));
    write_reg(REG_UNUSED_3, CFG_DATA_BITS'($urandom));

    // random phases, each under its own settings
    random_queued = 0;
    phase = 0;
    while (random_queued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: take = '0;
        1: take = TAKE_BITS'(1);
        2: take = TAKE_BITS'(64);
        3: take = TAKE_BITS'($urandom_range(65, 127));
        default: take = TAKE_BITS'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0: span = '0;
        1: span = '1;
        2: span = SPAN_BITS'($urandom_range(1, 63));
        default: span = SPAN_BITS'($urandom_range(1, 15));
      endcase
      write_reg(REG_TAKE_COUNT, CFG_DATA_BITS'(take));
      write_reg(REG_WINDOW_SPAN, {1'($urandom), span});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED_3, CFG_DATA_BITS'($urandom));
      // last stretch runs without idling
      if (RANDOM_ITEMS - random_queued < 150) idle_on = 1'b0;
      n = 0;
      if (phase == 3) begin
        // receiver holds off while short sequences keep coming
        pressure_on = 1'b1;
        while (n < 60) begin
          len = $urandom_range(1, 3);
          queue_sequence(len, 1'b1);
          n += len;
        end
      end else begin
        phase_goal = $urandom_range(60, 140);
        while (n < phase_goal) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 20);
          close = 1'b1;
          if (n + len >= phase_goal && idle_on && $urandom_range(0, 3) == 0) close = 1'b0;
          queue_sequence(len, close);
          n += len;
        end
      end
      random_queued += n;
      phase++;
      settle();
    end

    $display("Covered %0d sample beats in %0d closed sequences, %0d results checked,",
             beats_in, sequences, results_checked);
    $display("%0d register writes over %0d random phases, %0d errors",
             reg_writes, phase, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
